### design/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg: shared constants, microcode table and control types
// Widths of the key and limit fields, the modulo stepping constants, and
// the read-only control program that sequences one insertion.
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int KEY_W       = 31;
  localparam int LIMIT_W     = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

  // Remainder unit: eight key bits per step, four steps cover a padded key.
  localparam int MOD_BITS    = 8;
  localparam int MOD_STEPS   = 4;
  localparam int MOD_W       = MOD_BITS * MOD_STEPS;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  // Program steps
  localparam int STEP_W      = 3;
  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_MOD    = 3'd1;
  localparam logic [STEP_W-1:0] S_PROBE  = 3'd2;
  localparam logic [STEP_W-1:0] S_DECIDE = 3'd3;
  localparam logic [STEP_W-1:0] S_OK     = 3'd4;
  localparam logic [STEP_W-1:0] S_FAIL   = 3'd5;
  localparam logic [STEP_W-1:0] S_CLEAR  = 3'd6;

  // Datapath actions
  localparam int ACT_W       = 3;
  localparam logic [ACT_W-1:0] A_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] A_ACCEPT  = 3'd1;
  localparam logic [ACT_W-1:0] A_MOD     = 3'd2;
  localparam logic [ACT_W-1:0] A_PROBE   = 3'd3;
  localparam logic [ACT_W-1:0] A_SWAP    = 3'd4;
  localparam logic [ACT_W-1:0] A_POST_OK = 3'd5;
  localparam logic [ACT_W-1:0] A_POST_NG = 3'd6;
  localparam logic [ACT_W-1:0] A_CLEAR   = 3'd7;

  // Branch conditions
  localparam int COND_W      = 3;
  localparam logic [COND_W-1:0] C_ALWAYS     = 3'd0;
  localparam logic [COND_W-1:0] C_IN_VALID   = 3'd1;
  localparam logic [COND_W-1:0] C_MOD_LAST   = 3'd2;
  localparam logic [COND_W-1:0] C_LIMIT      = 3'd3;
  localparam logic [COND_W-1:0] C_SLOT_FREE  = 3'd4;
  localparam logic [COND_W-1:0] C_OUT_FREE   = 3'd5;
  localparam logic [COND_W-1:0] C_CLEAR_LAST = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] on_true;
    logic [STEP_W-1:0] on_false;
  } chi_uword_t;

  function automatic chi_uword_t chi_urom(input logic [STEP_W-1:0] step);
    chi_uword_t w;
    case (step)
      S_IDLE:   w = '{A_ACCEPT,  C_IN_VALID,   S_MOD,   S_IDLE};
      S_MOD:    w = '{A_MOD,     C_MOD_LAST,   S_PROBE, S_MOD};
      S_PROBE:  w = '{A_PROBE,   C_LIMIT,      S_FAIL,  S_DECIDE};
      S_DECIDE: w = '{A_SWAP,    C_SLOT_FREE,  S_OK,    S_PROBE};
      S_OK:     w = '{A_POST_OK, C_OUT_FREE,   S_IDLE,  S_OK};
      S_FAIL:   w = '{A_POST_NG, C_OUT_FREE,   S_IDLE,  S_FAIL};
      S_CLEAR:  w = '{A_CLEAR,   C_CLEAR_LAST, S_IDLE,  S_CLEAR};
      default:  w = '{A_NONE,    C_ALWAYS,     S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### design/chi_ram.sv
// ----------------------------------------------------------------------------
// chi_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module chi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/chi_mod.sv
// ----------------------------------------------------------------------------
// chi_mod: key remainder by a constant table size
// Restoring reduction, MSB first, a byte of the key per step.
// ----------------------------------------------------------------------------
module chi_mod #(
  parameter int DIVISOR = 8
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [chi_pkg::KEY_W-1:0]  key,
  output logic [$clog2(DIVISOR)-1:0] rem
);
  import chi_pkg::*;

  localparam int RW = $clog2(DIVISOR);
  localparam logic [RW:0] DW = (RW+1)'(DIVISOR);

  logic [MOD_W-1:0] sr;
  logic [RW-1:0]    acc;
  logic [RW:0]      r;

  // Shift in one bit, subtract the divisor when the partial value reaches it.
  always_comb begin
    r = {1'b0, acc};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[RW-1:0], sr[MOD_W-1-i]};
      if (r >= DW) begin
        r = r - DW;
      end
    end
    rem = r[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sr  <= MOD_W'(key);
      acc <= '0;
    end else if (step) begin
      sr  <= sr << MOD_BITS;
      acc <= rem;
    end
  end

endmodule

### design/cuckoo_hash_insert.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_insert: two-table cuckoo hash insertion
// Microcoded sequencer driving two table RAMs and two remainder units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one key per request. Each key
//   is inserted into table one at key mod FIRST_SIZE; an occupied slot is
//   taken over and the evicted key moves to the other table at its own slot,
//   alternating, until a free slot is found or max_placements placements
//   have been made. One result per request on out_valid/out_ready: placed,
//   and dropped_key (the key left without a slot, zero when placed).
//   Steps: an accept step, the remainder steps, then per placement a table
//   read and then a write-and-decide step, and a final post step. Giving
//   up costs one more read step. One key is in flight at a time.
//   Reset: a clearing pass writes every table entry empty, one row per cycle,
//   and in_ready stays low throughout the pass.
//   max_placements resets to 4 and is written through cfg_we/cfg_data.
//   Stall: a finished result waits in the output register; the block holds
//   its post step until that register drains, while an idle block still
//   takes the next request as soon as the result is queued.
// ----------------------------------------------------------------------------
module cuckoo_hash_insert #(
  parameter int FIRST_SIZE  = 8,
  parameter int SECOND_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [chi_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        placed,
  output logic [chi_pkg::KEY_W-1:0]   dropped_key,
  input  logic                        cfg_we,
  input  logic [chi_pkg::LIMIT_W-1:0] cfg_data
);
  import chi_pkg::*;

  localparam int S1W  = $clog2(FIRST_SIZE);
  localparam int S2W  = $clog2(SECOND_SIZE);
  // Entry layout: {valid, key, table-one slot, table-two slot}
  localparam int EW   = 1 + KEY_W + S1W + S2W;
  localparam int MAXS = (FIRST_SIZE > SECOND_SIZE) ? FIRST_SIZE : SECOND_SIZE;
  localparam int CLW  = $clog2(MAXS);

  // Sequencer
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  chi_uword_t        uw;
  logic              cond_hit;

  // Datapath registers
  logic [LIMIT_W-1:0]   max_placements;
  logic [LIMIT_W-1:0]   tries;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [KEY_W-1:0]     carried;
  logic [S1W-1:0]       slot1;
  logic [S2W-1:0]       slot2;
  logic                 in_first;
  logic [CLW-1:0]       clr_idx;

  // Remainder units
  logic [S1W-1:0] rem1;
  logic [S2W-1:0] rem2;

  // Table ports
  logic           we1, we2;
  logic [S1W-1:0] waddr1;
  logic [S2W-1:0] waddr2;
  logic [EW-1:0]  wdata1, wdata2, entry;
  logic [EW-1:0]  rdata1, rdata2, rd;
  logic           rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic [S1W-1:0] rd_s1;
  logic [S2W-1:0] rd_s2;
  logic           clr_in1, clr_in2;

  // Action decode
  logic act_accept, act_mod, act_swap, act_post, act_clear;
  logic out_free, accept, post_fire;

  assign uw         = chi_urom(pc);
  assign act_accept = (uw.act == A_ACCEPT);
  assign act_mod    = (uw.act == A_MOD);
  assign act_swap   = (uw.act == A_SWAP);
  assign act_post   = (uw.act == A_POST_OK) || (uw.act == A_POST_NG);
  assign act_clear  = (uw.act == A_CLEAR);

  assign in_ready  = act_accept;
  assign accept    = in_valid && act_accept;
  assign out_free  = !out_valid || out_ready;
  assign post_fire = act_post && out_free;

  // Pick the entry read for the table the carried key is headed to.
  assign rd       = in_first ? rdata1 : rdata2;
  assign rd_valid = rd[EW-1];
  assign rd_key   = rd[EW-2 -: KEY_W];
  assign rd_s1    = rd[S1W+S2W-1 -: S1W];
  assign rd_s2    = rd[S2W-1:0];

  // Branch condition select
  always_comb begin
    case (uw.cond)
      C_ALWAYS:     cond_hit = 1'b1;
      C_IN_VALID:   cond_hit = in_valid;
      C_MOD_LAST:   cond_hit = (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
      C_LIMIT:      cond_hit = (tries == max_placements);
      C_SLOT_FREE:  cond_hit = !rd_valid;
      C_OUT_FREE:   cond_hit = out_free;
      C_CLEAR_LAST: cond_hit = (clr_idx == CLW'(MAXS - 1));
      default:      cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? uw.on_true : uw.on_false;
  end

  // Table writes: clearing sweep, or store the carried key at its slot.
  assign clr_in1 = ({1'b0, clr_idx} < (CLW+1)'(FIRST_SIZE));
  assign clr_in2 = ({1'b0, clr_idx} < (CLW+1)'(SECOND_SIZE));
  assign entry   = {1'b1, carried, slot1, slot2};

  assign we1    = act_clear ? clr_in1 : (act_swap && in_first);
  assign we2    = act_clear ? clr_in2 : (act_swap && !in_first);
  assign waddr1 = act_clear ? clr_idx[S1W-1:0] : slot1;
  assign waddr2 = act_clear ? clr_idx[S2W-1:0] : slot2;
  assign wdata1 = act_clear ? '0 : entry;
  assign wdata2 = act_clear ? '0 : entry;

  chi_ram #(.WIDTH(EW), .DEPTH(FIRST_SIZE)) u_table1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .raddr (slot1),
    .rdata (rdata1)
  );

  chi_ram #(.WIDTH(EW), .DEPTH(SECOND_SIZE)) u_table2 (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr2),
    .wdata (wdata2),
    .raddr (slot2),
    .rdata (rdata2)
  );

  chi_mod #(.DIVISOR(FIRST_SIZE)) u_mod1 (
    .clk  (clk),
    .load (accept),
    .step (act_mod),
    .key  (key),
    .rem  (rem1)
  );

  chi_mod #(.DIVISOR(SECOND_SIZE)) u_mod2 (
    .clk  (clk),
    .load (accept),
    .step (act_mod),
    .key  (key),
    .rem  (rem2)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= S_CLEAR;
      clr_idx        <= '0;
      tries          <= '0;
      mod_cnt        <= '0;
      in_first       <= 1'b1;
      out_valid      <= 1'b0;
      max_placements <= LIMIT_RESET;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        max_placements <= cfg_data;
      end
      if (act_clear) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept) begin
        tries    <= '0;
        mod_cnt  <= '0;
        in_first <= 1'b1;
      end
      if (act_mod) begin
        mod_cnt <= mod_cnt + 1'b1;
      end
      // Advance to the other table only when a key was evicted.
      if (act_swap && rd_valid) begin
        tries    <= tries + 1'b1;
        in_first <= !in_first;
      end
      if (post_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      carried <= key;
    end
    if (act_mod) begin
      slot1 <= rem1;
      slot2 <= rem2;
    end
    // Take over the evicted occupant along with both of its slots.
    if (act_swap && rd_valid) begin
      carried <= rd_key;
      slot1   <= rd_s1;
      slot2   <= rd_s2;
    end
    if (post_fire) begin
      placed      <= (uw.act == A_POST_OK);
      dropped_key <= (uw.act == A_POST_OK) ? '0 : carried;
    end
  end

endmodule
